/* sv/cqr_pkg.sv */
// shared types and codes for the circular queue with reverse
// no dependencies

package cqr_pkg;

  localparam int DATA_W    = 32;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 8;
  localparam int DEPTH_DEF = 128;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REV = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic deq_read;
    logic fill_read;
  } cqr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
  } cqr_stat_t;

endpackage

/* sv/circular_queue_with_reverse.sv */
// results: enqueue, reverse and underflow give their result in the cycle after the transaction,
// a dequeue that reads the ram gives it via the ram read register, then the result register
// throughput: 1 transaction a cycle for enqueue and reverse while the result is taken,
// a dequeue holds off input until its ram data is loaded; reverse is a head move and flag flip
// reset: synchronous active-low rst_n empties the queue, ram contents are left as they are

module circular_queue_with_reverse
  import cqr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [DATA_W-1:0] in_item_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [STAT_W-1:0]        out_status,
  output logic [OCC_W-1:0]         out_occupancy,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  // commands down, status up
  cqr_cmd_t  cmd;
  cqr_stat_t stat;

  // controller: accepts a transaction when idle and the result register is free
  // or being drained in the same cycle
  cqr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: entries live in ram, order reversal handled by walk direction
  cqr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_action),
    .in_item_value  (in_item_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

endmodule

/* sv/cqr_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies

module cqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/cqr_ctrl.sv */
// handshake controller for the circular queue with reverse
// depends on cqr_pkg

module cqr_ctrl
  import cqr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  cqr_stat_t        stat,
  output cqr_cmd_t         cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept, deq_read;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  // a dequeue from a non-empty queue waits in S_READ for ram data
  assign deq_read = accept && (in_action == ACT_DEQ) && !stat.empty;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (deq_read) begin
          state_nxt = S_READ;
        end else if (accept) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_READ: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign cmd.accept    = accept;
  assign cmd.deq_read  = deq_read;
  assign cmd.fill_read = (state_r == S_READ);

endmodule

/* sv/cqr_dp.sv */
// datapath: head, count, direction flag, entry ram and result registers
// depends on cqr_pkg and cqr_ram

module cqr_dp
  import cqr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cqr_cmd_t                 cmd,
  output cqr_stat_t                stat,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [DATA_W-1:0] in_item_value,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [STAT_W-1:0]        out_status,
  output logic [OCC_W-1:0]         out_occupancy,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // base + off modulo depth, base below depth, off at most depth
  function automatic logic [AW-1:0] fwd(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // base - off modulo depth
  function automatic logic [AW-1:0] bwd(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    if (SW'(base) >= SW'(off)) begin
      s = SW'(base) - SW'(off);
    end else begin
      s = SW'(base) + SW'(DEPTH) - SW'(off);
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     rev_r, rev_nxt;
  logic                     we;
  logic [AW-1:0]            tail;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rdv_r, rdv_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic [OCC_W-1:0]         occ_r;
  logic                     empty_r, full_r;
  logic                     full;

  assign full       = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign tail       = rev_r ? bwd(head_r, count_r) : fwd(head_r, count_r);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    we         = 1'b0;
    rdv_nxt    = '0;
    status_nxt = ST_OK;
    unique case (in_action)
      ACT_ENQ: begin
        if (full) begin
          status_nxt = ST_OVER;
        end else begin
          we        = cmd.accept;
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_DEQ: begin
        if (stat.empty) begin
          rdv_nxt    = -32'sd1;
          status_nxt = ST_UNDER;
        end else begin
          head_nxt  = rev_r ? bwd(head_r, CW'(1)) : fwd(head_r, CW'(1));
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_REV: begin
        // with more than one entry, the newest entry becomes the head and walk direction flips
        if (count_r > CW'(1)) begin
          rev_nxt  = !rev_r;
          head_nxt = rev_r ? bwd(head_r, count_r - CW'(1))
                           : fwd(head_r, count_r - CW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (cmd.accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdv_r    <= rdv_nxt;
      status_r <= status_nxt;
      occ_r    <= OCC_W'(count_nxt);
      empty_r  <= (count_nxt == '0);
      full_r   <= (count_nxt == CW'(DEPTH));
    end else if (cmd.fill_read) begin
      rdv_r <= ram_rdata;
    end
  end

  cqr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (tail),
    .wdata (in_item_value),
    .re    (cmd.deq_read),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign out_read_value = rdv_r;
  assign out_status     = status_r;
  assign out_occupancy  = occ_r;
  assign out_is_empty   = empty_r;
  assign out_is_full    = full_r;

endmodule

/* sv/cqr_checker.sv */
// port-level checks for the circular queue with reverse, bound to the top level
// depends on cqr_pkg

module cqr_checker
  import cqr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic [STAT_W-1:0]        out_status,
  input logic [OCC_W-1:0]         out_occupancy,
  input logic                     out_is_empty,
  input logic                     out_is_full
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value) && $stable(out_status))
    else $error("result changed while stalled");

  // underflow reports minus one on an empty queue
  a_under: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNDER) |-> (out_read_value == -32'sd1) && out_is_empty)
    else $error("underflow result malformed");

  // overflow only happens on a full queue
  a_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OVER) |-> out_is_full && !out_is_empty)
    else $error("overflow while not full");

  // empty flag agrees with occupancy
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_occupancy == '0) && !out_is_full)
    else $error("empty flag disagrees with occupancy");

  // full flag agrees with occupancy
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_full |-> (out_occupancy == OCC_W'(DEPTH)))
    else $error("full flag disagrees with occupancy");

endmodule

bind circular_queue_with_reverse cqr_checker #(.DEPTH(DEPTH)) u_cqr_checker (.*);
